// ----- rtl/stepper_microstep_indexer_core_assert.svh -----
// Assertion macros for the microstep indexer.
`ifndef STEPPER_MICROSTEP_INDEXER_CORE_ASSERT_SVH
`define STEPPER_MICROSTEP_INDEXER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SMI_ASSERT_NOW(label, clk, rstn, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define SMI_ASSERT_NEXT(label, clk, rstn, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ----- rtl/smi_pkg.sv -----
// Shared types and constants of the microstep indexer.
package smi_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 64;

    localparam int OP_W       = 2;
    localparam int INDEX_W    = 6;
    localparam int PHASE_W    = 2;
    localparam int CURRENTS_W = 8;
    localparam int NIBBLE_W   = 4;
    localparam int CURRENT_W  = 8;
    localparam int POS_OUT_W  = 6;
    localparam int ENTRY_W    = PHASE_W + CURRENTS_W;

    localparam int STEP_COUNT_W    = 7;
    localparam int RANGE_W         = 2;
    localparam int DELAY_W         = 8;
    localparam int IDLE_W          = 8;
    localparam int CFG_DATA_W      = 8;
    localparam int CFG_INDEX_W     = 2;

    localparam logic [STEP_COUNT_W-1:0] STEP_COUNT_RESET = 7'd64;
    localparam logic [RANGE_W-1:0]      RANGE_RESET      = 2'd0;
    localparam logic [DELAY_W-1:0]      DELAY_RESET      = 8'd240;

    localparam logic [CURRENTS_W-1:0] NIBBLE_MASK = 8'h0F;
    localparam logic [PHASE_W-1:0]    PHASE_MASK  = 2'h3;
    localparam logic [PHASE_W-1:0]    PHASE_A_BIT = 2'h1;
    localparam logic [PHASE_W-1:0]    PHASE_B_BIT = 2'h2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_STEP_COUNT    = 2'd0,
        CFG_CURRENT_RANGE = 2'd1,
        CFG_STANDBY_DELAY = 2'd2,
        CFG_UNUSED        = 2'd3
    } cfg_index_t;

    typedef enum logic [OP_W-1:0] {
        OP_STEP = 2'd0,
        OP_TICK = 2'd1,
        OP_LOAD = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    typedef struct packed {
        op_t                  op;
        logic [POS_OUT_W-1:0] step_position;
    } item_t;

    typedef struct packed {
        logic [POS_OUT_W-1:0] step_position;
        logic                 standby;
        logic [CURRENT_W-1:0] current_b;
        logic [CURRENT_W-1:0] current_a;
        logic                 phase_b_forward;
        logic                 phase_a_forward;
    } result_t;

endpackage

// ----- rtl/smi_table.sv -----
// Microstep table memory: one write port, one registered read port.
module smi_table #(
    parameter int TABLE_DEPTH = smi_pkg::DEFAULT_TABLE_DEPTH,
    parameter int AW          = $clog2(TABLE_DEPTH)
) (
    input  logic                       aclk,
    input  logic                       wr_en,
    input  logic [AW-1:0]              wr_addr,
    input  logic [smi_pkg::ENTRY_W-1:0] wr_data,
    input  logic                       rd_en,
    input  logic [AW-1:0]              rd_addr,
    output logic [smi_pkg::ENTRY_W-1:0] rd_data
);
    import smi_pkg::*;

    logic [ENTRY_W-1:0] mem [TABLE_DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/smi_front.sv -----
// Request intake: position update and table access.
module smi_front #(
    parameter int TABLE_DEPTH = smi_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             accept,
    input  smi_pkg::op_t                     op,
    input  logic                             forward,
    input  logic [smi_pkg::INDEX_W-1:0]      entry_index,
    input  logic [smi_pkg::PHASE_W-1:0]      entry_phase_bits,
    input  logic [smi_pkg::CURRENTS_W-1:0]   entry_currents,
    input  logic [smi_pkg::STEP_COUNT_W-1:0] step_count,
    input  logic                             p1_advance,
    output logic                             p1_valid,
    output smi_pkg::item_t                   p1_item,
    output logic [smi_pkg::ENTRY_W-1:0]      rd_entry
);
    import smi_pkg::*;

    localparam int PW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = (PW + 1 > STEP_COUNT_W) ? PW + 1 : STEP_COUNT_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    logic [PW-1:0] position_reg, position_next;
    logic          p1_valid_reg, p1_valid_next;
    item_t         item_reg;
    logic [CW-1:0] cnt, len, pos_ext, inc, target;
    logic          is_step, is_load;

    always_comb begin
        cnt     = CW'(step_count);
        if (cnt == '0) begin
            len = CW'(1);
        end else if (cnt > DEPTH_C) begin
            len = DEPTH_C;
        end else begin
            len = cnt;
        end
        pos_ext = CW'(position_reg);
        inc     = pos_ext + CW'(1);
        if (forward) begin
            target = (inc >= len) ? '0 : inc;
        end else begin
            target = (pos_ext == '0 || pos_ext >= len) ? len - CW'(1) : pos_ext - CW'(1);
        end
        is_step = accept && (op == OP_STEP);
        is_load = accept && (op == OP_LOAD) && (CW'(entry_index) < DEPTH_C);
        position_next = is_step ? PW'(target) : position_reg;
        if (accept) begin
            p1_valid_next = 1'b1;
        end else if (p1_advance) begin
            p1_valid_next = 1'b0;
        end else begin
            p1_valid_next = p1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            position_reg <= '0;
            p1_valid_reg <= 1'b0;
        end else begin
            position_reg <= position_next;
            p1_valid_reg <= p1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg.op            <= op;
            item_reg.step_position <= POS_OUT_W'(position_next);
        end
    end

    smi_table #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .AW          (PW)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (is_load),
        .wr_addr (PW'(entry_index)),
        .wr_data ({entry_currents, entry_phase_bits & PHASE_MASK}),
        .rd_en   (is_step),
        .rd_addr (PW'(target)),
        .rd_data (rd_entry)
    );

    assign p1_valid = p1_valid_reg;
    assign p1_item  = item_reg;

endmodule

// ----- rtl/smi_drive.sv -----
// Current, phase and standby update with the result register.
module smi_drive (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           p1_valid,
    input  smi_pkg::item_t                 p1_item,
    input  logic [smi_pkg::ENTRY_W-1:0]    rd_entry,
    input  logic [smi_pkg::RANGE_W-1:0]    current_range,
    input  logic [smi_pkg::DELAY_W-1:0]    standby_delay,
    input  logic                           m_ready,
    output logic                           p1_advance,
    output logic                           m_valid,
    output smi_pkg::result_t               m_result
);
    import smi_pkg::*;

    logic [PHASE_W-1:0]   phase_reg, phase_next;
    logic [CURRENT_W-1:0] cur_a_reg, cur_a_next, cur_b_reg, cur_b_next;
    logic [IDLE_W-1:0]    idle_reg, idle_next, idle_inc;
    logic                 standby_reg, standby_next;
    logic                 m_valid_reg, m_valid_next;
    result_t              result_reg, result_next;
    logic [CURRENTS_W-1:0] currents;
    logic [2:0]           shift;

    always_comb begin
        p1_advance   = p1_valid && (!m_valid_reg || m_ready);
        currents     = rd_entry[ENTRY_W-1:PHASE_W];
        shift        = 3'(current_range) + 3'd1;
        idle_inc     = idle_reg + IDLE_W'(1);
        phase_next   = phase_reg;
        cur_a_next   = cur_a_reg;
        cur_b_next   = cur_b_reg;
        idle_next    = idle_reg;
        standby_next = standby_reg;
        if (p1_advance) begin
            case (p1_item.op)
                OP_STEP: begin
                    phase_next   = rd_entry[PHASE_W-1:0] & PHASE_MASK;
                    cur_a_next   = (currents & NIBBLE_MASK) << shift;
                    cur_b_next   = (currents >> NIBBLE_W) << shift;
                    standby_next = 1'b0;
                    idle_next    = '0;
                end
                OP_TICK: begin
                    if (!standby_reg) begin
                        idle_next = idle_inc;
                        if (idle_inc > standby_delay) begin
                            standby_next = 1'b1;
                            cur_a_next   = cur_a_reg >> 1;
                            cur_b_next   = cur_b_reg >> 1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
        result_next.phase_a_forward = |(phase_next & PHASE_A_BIT);
        result_next.phase_b_forward = |(phase_next & PHASE_B_BIT);
        result_next.current_a       = cur_a_next;
        result_next.current_b       = cur_b_next;
        result_next.standby         = standby_next;
        result_next.step_position   = p1_item.step_position;
        if (p1_advance) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= '0;
            cur_a_reg   <= '0;
            cur_b_reg   <= '0;
            idle_reg    <= '0;
            standby_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            cur_a_reg   <= cur_a_next;
            cur_b_reg   <= cur_b_next;
            idle_reg    <= idle_next;
            standby_reg <= standby_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (p1_advance) begin
            result_reg <= result_next;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_result = result_reg;

endmodule

// ----- rtl/stepper_microstep_indexer_core.sv -----
// Step/direction microstep indexer for a two-phase stepper, top level.
//
// Requests enter on the s_ stream: s_tuser carries the operation (step, tick,
// load table entry), s_tdata carries direction, entry index, phase bits and
// current codes. Each request yields exactly one result on the m_ stream:
// phase polarities, both current setpoints, standby flag and step position.
// Configuration registers (step count, current range, standby delay) are
// written through cfg_wen / cfg_index / cfg_wdata while no request is open.
// The accepting edge updates the position and issues the synchronous table
// read; when the table-read stage advances, the current scaling and standby
// logic are loaded into the result register, which raises m_tvalid. One
// request per cycle is sustained while m_tready stays high. When the
// receiver stalls, the result register holds; one more request is taken
// into the table-read stage, after which s_tready drops until the result
// moves on. During reset s_tready is low. Reset clears the position, phase
// bits, currents, idle count and standby flag and restores the configuration
// defaults; table contents are undefined until loaded and no clearing pass is
// needed.
module stepper_microstep_indexer_core #(
    parameter int TABLE_DEPTH = smi_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [0] forward, [6:1] entry_index, [8:7] entry_phase_bits, [16:9] entry_currents
    input  logic [23:0]                       s_tdata,
    // [1:0] op
    input  logic [smi_pkg::OP_W-1:0]          s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [0] phase_a_forward, [1] phase_b_forward, [9:2] current_a,
    // [17:10] current_b, [18] standby, [24:19] step_position
    output logic [31:0]                       m_tdata,
    input  logic                              cfg_wen,
    input  logic [smi_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [smi_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import smi_pkg::*;

`include "stepper_microstep_indexer_core_assert.svh"

    logic [STEP_COUNT_W-1:0] step_count_reg;
    logic [RANGE_W-1:0]      range_reg;
    logic [DELAY_W-1:0]      delay_reg;
    logic                    accept, p1_valid, p1_advance;
    item_t                   p1_item;
    logic [ENTRY_W-1:0]      rd_entry;
    result_t                 result;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_count_reg <= STEP_COUNT_RESET;
            range_reg      <= RANGE_RESET;
            delay_reg      <= DELAY_RESET;
        end else if (cfg_wen) begin
            case (cfg_index_t'(cfg_index))
                CFG_STEP_COUNT:    step_count_reg <= cfg_wdata[STEP_COUNT_W-1:0];
                CFG_CURRENT_RANGE: range_reg      <= cfg_wdata[RANGE_W-1:0];
                CFG_STANDBY_DELAY: delay_reg      <= cfg_wdata[DELAY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign s_tready = aresetn && (!p1_valid || p1_advance);
    assign accept   = s_tvalid && s_tready;

    smi_front #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .accept           (accept),
        .op               (op_t'(s_tuser)),
        .forward          (s_tdata[0]),
        .entry_index      (s_tdata[6:1]),
        .entry_phase_bits (s_tdata[8:7]),
        .entry_currents   (s_tdata[16:9]),
        .step_count       (step_count_reg),
        .p1_advance       (p1_advance),
        .p1_valid         (p1_valid),
        .p1_item          (p1_item),
        .rd_entry         (rd_entry)
    );

    smi_drive u_drive (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .p1_valid      (p1_valid),
        .p1_item       (p1_item),
        .rd_entry      (rd_entry),
        .current_range (range_reg),
        .standby_delay (delay_reg),
        .m_ready       (m_tready),
        .p1_advance    (p1_advance),
        .m_valid       (m_tvalid),
        .m_result      (result)
    );

    assign m_tdata = {7'd0, result.step_position, result.standby, result.current_b,
                      result.current_a, result.phase_b_forward, result.phase_a_forward};

    `SMI_ASSERT_NEXT(a_accept_fills_stage, aclk, aresetn, accept, p1_valid,
        "accepted request did not reach the table-read stage")
    `SMI_ASSERT_NOW(a_no_overrun, aclk, aresetn, p1_valid && !p1_advance, !s_tready,
        "request taken while the table-read stage was stalled")
    `SMI_ASSERT_NOW(a_standby_halved, aclk, aresetn, m_tvalid && m_tdata[18],
        !m_tdata[9] && !m_tdata[17], "standby result shows unhalved current")

endmodule

// ----- test/stepper_indexer_checker.sv -----
`timescale 1ns / 1ps
// Checker for the microstep indexer: tracks position, table and standby state, compares results.
module stepper_indexer_checker
    import smi_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [23:0]            s_tdata,
    input  logic [OP_W-1:0]        s_tuser,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [31:0]            m_tdata,
    input  logic                   cfg_wen,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    output int                     fail_count,
    output int                     pending,
    output int                     result_count
);

    localparam int DEPTH = DEFAULT_TABLE_DEPTH;

    logic [STEP_COUNT_W-1:0] step_count;
    logic [RANGE_W-1:0]      current_range;
    logic [DELAY_W-1:0]      standby_delay;

    logic [PHASE_W-1:0]    tbl_phase [DEPTH];
    logic [CURRENTS_W-1:0] tbl_currents [DEPTH];
    logic [POS_OUT_W-1:0]  pos;
    logic [PHASE_W-1:0]    phase;
    logic [CURRENT_W-1:0]  cur_a;
    logic [CURRENT_W-1:0]  cur_b;
    logic [IDLE_W-1:0]     idle;
    logic                  standby;

    result_t setpoint_q[$];

    task automatic advance_indexer(input op_t op, input logic [23:0] d, output result_t r);
        int len;
        int nxt;
        int mult_shift;
        logic [CURRENTS_W-1:0] codes;
        len = (step_count == 0) ? 1 : (int'(step_count) > DEPTH) ? DEPTH : int'(step_count);
        mult_shift = int'(current_range) + 1;
        case (op)
            OP_STEP: begin
                if (d[0]) begin
                    nxt = int'(pos) + 1;
                    pos = (nxt >= len) ? '0 : POS_OUT_W'(nxt);
                end else if (pos == 0 || int'(pos) >= len) begin
                    pos = POS_OUT_W'(len - 1);
                end else begin
                    pos = pos - 1'b1;
                end
                codes = tbl_currents[pos];
                phase = tbl_phase[pos] & PHASE_MASK;
                cur_a = CURRENT_W'(codes & NIBBLE_MASK) << mult_shift;
                cur_b = CURRENT_W'(codes >> NIBBLE_W) << mult_shift;
                standby = 1'b0;
                idle = '0;
            end
            OP_TICK: begin
                if (!standby) begin
                    idle = idle + 1'b1;
                    if (idle > standby_delay) begin
                        standby = 1'b1;
                        cur_a = cur_a >> 1;
                        cur_b = cur_b >> 1;
                    end
                end
            end
            OP_LOAD: begin
                tbl_phase[d[6:1]] = d[8:7];
                tbl_currents[d[6:1]] = d[16:9];
            end
            default: ;
        endcase
        r.phase_a_forward = |(phase & PHASE_A_BIT);
        r.phase_b_forward = |(phase & PHASE_B_BIT);
        r.current_a = cur_a;
        r.current_b = cur_b;
        r.standby = standby;
        r.step_position = pos;
    endtask

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            fail_count++;
            $display("%0t checker: %s mismatch, expected %0d, actual %0d",
                     $time, name, want, got);
        end
    endfunction

    always @(posedge aclk) begin
        result_t want;
        result_t got;
        if (!aresetn) begin
            step_count = STEP_COUNT_RESET;
            current_range = RANGE_RESET;
            standby_delay = DELAY_RESET;
            pos = '0;
            phase = '0;
            cur_a = '0;
            cur_b = '0;
            idle = '0;
            standby = 1'b0;
            setpoint_q.delete();
        end else begin
            if (cfg_wen) begin
                case (cfg_index_t'(cfg_index))
                    CFG_STEP_COUNT:    step_count = cfg_wdata[STEP_COUNT_W-1:0];
                    CFG_CURRENT_RANGE: current_range = cfg_wdata[RANGE_W-1:0];
                    CFG_STANDBY_DELAY: standby_delay = cfg_wdata[DELAY_W-1:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata[$bits(result_t)-1:0];
                result_count++;
                if (setpoint_q.size() == 0) begin
                    fail_count++;
                    $display("%0t checker: result with none expected, expected nothing, actual %h",
                             $time, got);
                end else begin
                    want = setpoint_q.pop_front();
                    check_field("phase_a_forward", want.phase_a_forward, got.phase_a_forward);
                    check_field("phase_b_forward", want.phase_b_forward, got.phase_b_forward);
                    check_field("current_a", want.current_a, got.current_a);
                    check_field("current_b", want.current_b, got.current_b);
                    check_field("standby", want.standby, got.standby);
                    check_field("step_position", want.step_position, got.step_position);
                end
            end
            if (s_tvalid && s_tready) begin
                advance_indexer(op_t'(s_tuser), s_tdata, want);
                setpoint_q.push_back(want);
            end
        end
        pending = setpoint_q.size();
    end

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// Testbench top for the microstep indexer: stimulus, flow pacing, watchdog and verdict.
module tb;
    import smi_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_ITEMS = 100;
    localparam int RANDOM_PHASES = 12;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [23:0]            s_tdata = '0;
    logic [OP_W-1:0]        s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [31:0]            m_tdata;
    logic                   cfg_wen = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    int fail_count;
    int pending;
    int result_count;
    int src_pct = 0;
    int snk_pct = 0;
    int request_count = 0;
    int setting_count = 0;
    int quiet_cycles = 0;

    stepper_microstep_indexer_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    stepper_indexer_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .cfg_wen      (cfg_wen),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .fail_count   (fail_count),
        .pending      (pending),
        .result_count (result_count)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_tready <= (snk_pct == 0) || ($urandom_range(99) >= snk_pct);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("tb: no handshake for %0d cycles, %0d results outstanding",
                     WATCHDOG_LIMIT, pending);
            $display("tb: FAIL");
            $finish;
        end
    end

    task automatic send(input op_t op, input logic [16:0] fields);
        while (src_pct != 0 && $urandom_range(99) < src_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {7'b0, fields};
        do @(posedge aclk); while (!s_tready);
        request_count++;
    endtask

    task automatic step_dir(input logic fwd);
        logic [16:0] d;
        d = 17'($urandom());
        d[0] = fwd;
        send(OP_STEP, d);
    endtask

    task automatic load(input logic [5:0] idx, input logic [1:0] ph, input logic [7:0] cur);
        send(OP_LOAD, {cur, ph, idx, 1'($urandom())});
    endtask

    // hold off until every outstanding request has produced its result
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (2) @(posedge aclk);
    endtask

    task automatic program_regs(input logic [7:0] sc, input logic [7:0] rng,
                                input logic [7:0] dly);
        cfg_wen <= 1'b1;
        cfg_index <= CFG_STEP_COUNT;
        cfg_wdata <= sc;
        @(posedge aclk);
        cfg_index <= CFG_CURRENT_RANGE;
        cfg_wdata <= rng;
        @(posedge aclk);
        cfg_index <= CFG_STANDBY_DELAY;
        cfg_wdata <= dly;
        @(posedge aclk);
        cfg_index <= CFG_UNUSED;
        cfg_wdata <= 8'($urandom());
        @(posedge aclk);
        cfg_wen <= 1'b0;
        setting_count++;
    endtask

    task automatic run_burst(input int dly);
        int len;
        int kind;
        logic fwd;
        kind = $urandom_range(99);
        if (kind < 45) begin
            len = $urandom_range(1, 10);
            fwd = 1'($urandom());
            repeat (len) step_dir(($urandom_range(4) == 0) ? ~fwd : fwd);
        end else if (kind < 80) begin
            len = ($urandom_range(3) == 0) ? dly + 2 : $urandom_range(1, 6);
            repeat (len) send(OP_TICK, 17'($urandom()));
        end else if (kind < 93) begin
            load(6'($urandom()), 2'($urandom()), 8'($urandom()));
        end else if (kind < 97) begin
            send(OP_NONE, 17'($urandom()));
        end else begin
            drain();
        end
    endtask

    initial begin
        int sc_list [RANDOM_PHASES];
        int dly_list [RANDOM_PHASES];
        int target;
        sc_list = '{64, 1, 0, 127, 2, 64, 17, 65, 3, 64, 40, 100};
        dly_list = '{0, 255, 3, 1, 240, 7, 0, 2, 255, 5, 1, 0};

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset configuration: wrap both ways around a full cycle
        load(6'd0, 2'd3, 8'hFF);
        load(6'd1, 2'd0, 8'h00);
        load(6'd2, 2'd1, 8'h0F);
        load(6'd3, 2'd2, 8'hF0);
        load(6'd63, 2'd3, 8'hA5);
        step_dir(1'b1);
        step_dir(1'b1);
        step_dir(1'b0);
        step_dir(1'b0);
        step_dir(1'b0);
        step_dir(1'b1);
        step_dir(1'b0);
        send(OP_TICK, 17'($urandom()));
        send(OP_NONE, 17'($urandom()));
        drain();

        // position past a short cycle, largest scale, immediate standby
        program_regs(8'h84, 8'hFF, 8'd0);
        step_dir(1'b1);
        send(OP_TICK, 17'($urandom()));
        send(OP_TICK, 17'($urandom()));
        step_dir(1'b0);
        drain();

        // zero step count acts as a single entry
        program_regs(8'd0, 8'd1, 8'd1);
        step_dir(1'b0);
        step_dir(1'b1);
        send(OP_TICK, 17'($urandom()));
        send(OP_TICK, 17'($urandom()));
        drain();

        // step count above the table depth
        program_regs(8'd127, 8'd2, 8'd240);
        step_dir(1'b0);
        step_dir(1'b1);

        // fill the whole table before free-running stimulus
        src_pct = 8;
        snk_pct = 8;
        for (int i = 0; i < DEFAULT_TABLE_DEPTH; i++) begin
            load(6'(i), 2'($urandom()), 8'($urandom()));
        end

        for (int k = 0; k < RANDOM_PHASES; k++) begin
            case (k % 4)
                0: begin src_pct = 0;  snk_pct = 0;  end
                1: begin src_pct = 57; snk_pct = 0;  end
                2: begin src_pct = 0;  snk_pct = 57; end
                default: begin src_pct = 8; snk_pct = 8; end
            endcase
            drain();
            program_regs({1'($urandom()), 7'(sc_list[k])},
                         {6'($urandom()), 2'(k % 4)}, 8'(dly_list[k]));
            target = request_count + PHASE_ITEMS;
            while (request_count < target) run_burst(dly_list[k]);
        end

        drain();
        repeat (8) @(posedge aclk);
        $display("tb: %0d requests, %0d results checked over %0d register settings",
                 request_count, result_count, setting_count);
        $display("tb: included cycle wrap both ways, zero and oversized step counts, standby");
        if (fail_count == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
